// File: rtl/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg: shared types, constants and helpers of the ASCII CAN command parser
// Holds the command letters, the job and result records, the reply text tables
// and the hex digit decoder.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] CMD_STD_DATA = 8'h74;   // 't'
    localparam logic [7:0] CMD_EXT_DATA = 8'h54;   // 'T'
    localparam logic [7:0] CMD_STD_RTR  = 8'h72;   // 'r'
    localparam logic [7:0] CMD_EXT_RTR  = 8'h52;   // 'R'
    localparam logic [7:0] CMD_VERSION  = 8'h56;   // 'V'
    localparam logic [7:0] CMD_SERIAL   = 8'h4E;   // 'N'

    localparam logic [7:0] CHAR_ACK_EXT = 8'h5A;   // 'Z'
    localparam logic [7:0] CHAR_ACK_STD = 8'h7A;   // 'z'
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_BELL    = 8'h07;

    localparam logic [4:0] POS_MAX      = 5'd31;
    localparam logic [2:0] TEXT_LAST    = 3'd5;

    typedef enum logic [2:0] {
        JOB_FRAME,
        JOB_VERSION,
        JOB_SERIAL,
        JOB_ACK,
        JOB_BELL
    } job_kind_t;

    typedef struct packed {
        job_kind_t    kind;
        logic         rtr;
        logic         ext;
        logic [28:0]  id;
        logic [3:0]   len;
        logic [63:0]  payload;
    } job_t;

    typedef struct packed {
        logic         kind;
        logic         rtr;
        logic         ext;
        logic [28:0]  id;
        logic [3:0]   len;
        logic [63:0]  payload;
        logic [7:0]   reply;
        logic         last;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        return v;
    endfunction

    function automatic logic [7:0] text_char(input logic serial, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CHAR_CR;
        if (!serial) begin
            unique case (idx)
                3'd0:    ch = 8'h56;
                3'd1:    ch = 8'h30;
                3'd2:    ch = 8'h34;
                3'd3:    ch = 8'h30;
                3'd4:    ch = 8'h32;
                default: ch = CHAR_CR;
            endcase
        end
        else begin
            unique case (idx)
                3'd0:    ch = 8'h4E;
                3'd1:    ch = 8'h4B;
                3'd2:    ch = 8'h52;
                3'd3:    ch = 8'h4F;
                3'd4:    ch = 8'h42;
                default: ch = CHAR_CR;
            endcase
        end
        return ch;
    endfunction

endpackage

// File: rtl/acp_front.sv
// ----------------------------------------------------------------------------
// acp_front: command byte parser
// Accepts command bytes and transmit outcomes, accumulates identifier, length
// and data digits, and pushes one job per frame, version, serial or outcome.
// ----------------------------------------------------------------------------
module acp_front #(
    parameter int MAX_DATA_BYTES = acp_pkg::MAX_DATA_BYTES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [7:0]                cmd_byte,
    input  logic                      end_of_command,
    input  logic                      tx_ok,
    input  acp_pkg::queue_status_t    q_status,
    output logic                      push,
    output acp_pkg::job_t             push_job
);
    import acp_pkg::*;

    localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

    logic [4:0]  pos_reg,      pos_next;
    logic [7:0]  letter_reg,   letter_next;
    logic [31:0] id_reg,       id_next;
    logic [3:0]  len_reg,      len_next;
    logic [63:0] pay_reg,      pay_next;
    logic        last_ext_reg, last_ext_next;

    logic        accept;
    logic [3:0]  nib;
    logic        cur_ext;
    logic        cur_std;
    logic [4:0]  id_digits;
    logic [4:0]  data_ofs;
    logic [3:0]  byte_idx;
    logic        new_ext;
    logic        new_rtr;
    logic        is_frame;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign nib      = hex_value(cmd_byte);

    assign cur_ext   = (letter_reg == CMD_EXT_DATA) || (letter_reg == CMD_EXT_RTR);
    assign cur_std   = (letter_reg == CMD_STD_DATA) || (letter_reg == CMD_STD_RTR);
    assign id_digits = cur_ext ? 5'd8 : 5'd3;
    assign data_ofs  = pos_reg - (id_digits + 5'd2);
    assign byte_idx  = data_ofs[4:1];

    always_comb
    begin
        pos_next      = pos_reg;
        letter_next   = letter_reg;
        id_next       = id_reg;
        len_next      = len_reg;
        pay_next      = pay_reg;
        last_ext_next = last_ext_reg;
        push          = 1'b0;
        push_job      = '0;
        new_ext       = 1'b0;
        new_rtr       = 1'b0;
        is_frame      = 1'b0;

        if (accept && !req_type) begin
            if (pos_reg == '0) begin
                letter_next = cmd_byte;
                id_next     = '0;
                len_next    = '0;
                pay_next    = '0;
            end
            else if (cur_ext || cur_std) begin
                if (pos_reg <= id_digits) begin
                    id_next = {id_reg[27:0], nib};
                end
                else if (pos_reg == id_digits + 5'd1) begin
                    len_next = (nib > MAX_LEN) ? MAX_LEN : nib;
                end
                else begin
                    for (int i = 0; i < 8; i++) begin
                        if (byte_idx == 4'(i) && 4'(i) < len_reg) begin
                            if (!data_ofs[0]) pay_next[i*8+4 +: 4] = pay_reg[i*8+4 +: 4] | nib;
                            else              pay_next[i*8 +: 4]   = pay_reg[i*8 +: 4] | nib;
                        end
                    end
                end
            end

            if (!end_of_command) begin
                if (pos_reg < POS_MAX) pos_next = pos_reg + 5'd1;
            end
            else begin
                pos_next = '0;
                new_ext  = (letter_next == CMD_EXT_DATA) || (letter_next == CMD_EXT_RTR);
                new_rtr  = (letter_next == CMD_STD_RTR) || (letter_next == CMD_EXT_RTR);
                case (letter_next) inside
                    CMD_STD_DATA, CMD_EXT_DATA, CMD_STD_RTR, CMD_EXT_RTR:
                    begin
                        is_frame         = 1'b1;
                        push             = 1'b1;
                        push_job.kind    = JOB_FRAME;
                        push_job.rtr     = new_rtr;
                        push_job.ext     = new_ext;
                        push_job.id      = id_next[28:0];
                        push_job.len     = len_next;
                        push_job.payload = pay_next;
                    end
                    CMD_VERSION:
                    begin
                        push          = 1'b1;
                        push_job.kind = JOB_VERSION;
                    end
                    CMD_SERIAL:
                    begin
                        push          = 1'b1;
                        push_job.kind = JOB_SERIAL;
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
                if (is_frame) last_ext_next = new_ext;
            end
        end
        else if (accept) begin
            push          = 1'b1;
            push_job.kind = tx_ok ? JOB_ACK : JOB_BELL;
            push_job.ext  = last_ext_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg      <= '0;
            letter_reg   <= '0;
            id_reg       <= '0;
            len_reg      <= '0;
            pay_reg      <= '0;
            last_ext_reg <= 1'b0;
        end
        else begin
            pos_reg      <= pos_next;
            letter_reg   <= letter_next;
            id_reg       <= id_next;
            len_reg      <= len_next;
            pay_reg      <= pay_next;
            last_ext_reg <= last_ext_next;
        end
    end

endmodule

// File: rtl/acp_queue.sv
// ----------------------------------------------------------------------------
// acp_queue: job queue
// Short first-in first-out queue of jobs between the parser and the result
// sequencer.
// ----------------------------------------------------------------------------
module acp_queue #(
    parameter int DEPTH = acp_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  acp_pkg::job_t             push_job,
    input  logic                      pop,
    output acp_pkg::job_t             head_job,
    output acp_pkg::queue_status_t    q_status
);
    import acp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign head_job       = entries_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push) entries_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/acp_back.sv
// ----------------------------------------------------------------------------
// acp_back: result sequencer
// Expands each queued job into its result transactions and holds them in the
// output register until taken.
// ----------------------------------------------------------------------------
module acp_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  acp_pkg::job_t             head_job,
    input  acp_pkg::queue_status_t    q_status,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output acp_pkg::result_t          result
);
    import acp_pkg::*;

    logic [2:0] idx_reg,   idx_next;
    logic       valid_reg, valid_next;
    result_t    res_reg;
    result_t    cur;
    logic       load;

    always_comb
    begin
        cur = '0;
        unique case (head_job.kind)
            JOB_FRAME:
            begin
                cur.rtr     = head_job.rtr;
                cur.ext     = head_job.ext;
                cur.id      = head_job.id;
                cur.len     = head_job.len;
                cur.payload = head_job.payload;
                cur.last    = 1'b1;
            end
            JOB_VERSION:
            begin
                cur.kind  = 1'b1;
                cur.reply = text_char(1'b0, idx_reg);
                cur.last  = (idx_reg == TEXT_LAST);
            end
            JOB_SERIAL:
            begin
                cur.kind  = 1'b1;
                cur.reply = text_char(1'b1, idx_reg);
                cur.last  = (idx_reg == TEXT_LAST);
            end
            JOB_ACK:
            begin
                cur.kind = 1'b1;
                if (idx_reg == '0) begin
                    cur.reply = head_job.ext ? CHAR_ACK_EXT : CHAR_ACK_STD;
                end
                else begin
                    cur.reply = CHAR_CR;
                    cur.last  = 1'b1;
                end
            end
            default:
            begin
                cur.kind  = 1'b1;
                cur.reply = CHAR_BELL;
                cur.last  = 1'b1;
            end
        endcase
    end

    assign load = !q_status.empty && (!valid_reg || out_ready);
    assign pop  = load && cur.last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = cur.last ? '0 : idx_reg + 3'd1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) res_reg <= cur;
    end

    assign out_valid = valid_reg;
    assign result    = res_reg;

endmodule

// File: rtl/ascii_can_command_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_can_command_parser_core: ASCII CAN adapter command parser
// Input channel (in_valid/in_ready) takes one command byte or one transmit
// outcome per transaction; output channel (out_valid/out_ready) returns CAN
// frames to send and reply characters for the host.
// The parser takes one input transaction per cycle while its job queue has
// room. A byte that ends a frame, version or serial command, and every
// transmit outcome, queues one job; while the output is taken, the sequencer
// turns a job into one result per cycle (frame: 1, outcome: 1 or 2, version
// or serial: 6). A job is written into the queue, then loaded into the
// output register, which raises out_valid when the output side is free.
// The sequencer sets the sustained rate, one result per cycle while out_ready
// is high; long reply runs fill the queue and in_ready drops until it catches up.
// When out_ready is low the output register holds its result, the sequencer
// stalls, and the parser keeps taking bytes until the queue is full.
// Reset clears the parse state, empties the queue and drops out_valid.
// ----------------------------------------------------------------------------
module ascii_can_command_parser_core #(
    parameter int MAX_DATA_BYTES = acp_pkg::MAX_DATA_BYTES,
    parameter int QUEUE_DEPTH    = acp_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  cmd_byte,
    input  logic        end_of_command,
    input  logic        tx_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_kind,
    output logic        frame_rtr,
    output logic        frame_extended,
    output logic [28:0] frame_id,
    output logic [3:0]  frame_length,
    output logic [63:0] frame_payload,
    output logic [7:0]  reply_char,
    output logic        last_of_run
);
    import acp_pkg::*;

    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head_job;
    queue_status_t q_status;
    result_t       result;

    acp_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .cmd_byte       (cmd_byte),
        .end_of_command (end_of_command),
        .tx_ok          (tx_ok),
        .q_status       (q_status),
        .push           (push),
        .push_job       (push_job)
    );

    acp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    acp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign out_kind       = result.kind;
    assign frame_rtr      = result.rtr;
    assign frame_extended = result.ext;
    assign frame_id       = result.id;
    assign frame_length   = result.len;
    assign frame_payload  = result.payload;
    assign reply_char     = result.reply;
    assign last_of_run    = result.last;

endmodule

// File: dv/ascii_can_command_parser_tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for ascii_can_command_parser_core
// Feeds command lines one byte per transaction, mixed with transmit outcomes,
// and predicts every frame and reply character in a scoreboard class. Runs
// directed commands first, then random lines over phases of input gaps and
// output stalls, including one long output hold that backs up the input.
// ----------------------------------------------------------------------------
module tb;

    import acp_pkg::*;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_OUTCOME = 1'b1;
    localparam logic OUT_FRAME   = 1'b0;
    localparam logic OUT_REPLY   = 1'b1;

    localparam logic [47:0] VERSION_TEXT = {"V0402", 8'h0D};
    localparam logic [47:0] SERIAL_TEXT  = 48'h4E4B524F420D;

    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 16;
    localparam int PHASE_ITEMS    = 62;

    class cmd_parse_scoreboard;
        result_t     pending[$];
        int unsigned errors = 0;
        logic [4:0]  parse_pos = '0;
        logic [7:0]  cmd_letter = '0;
        logic [31:0] ident = '0;
        logic [3:0]  dlc = '0;
        logic [63:0] data_bytes = '0;
        logic        last_frame_ext = 1'b0;

        function logic [3:0] nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return 4'(c - "0");
            if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
            if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
            return 4'd0;
        endfunction

        function void push_reply(logic [7:0] ch, logic last);
            result_t r;
            r = '0;
            r.kind  = OUT_REPLY;
            r.reply = ch;
            r.last  = last;
            pending.push_back(r);
        endfunction

        function void take_digit(logic [3:0] nib);
            logic        is_ext;
            logic        is_std;
            int unsigned id_digits;
            int unsigned d;
            int unsigned idx;
            int unsigned sh;
            is_ext = (cmd_letter == CMD_EXT_DATA || cmd_letter == CMD_EXT_RTR);
            is_std = (cmd_letter == CMD_STD_DATA || cmd_letter == CMD_STD_RTR);
            if (!is_ext && !is_std) return;
            id_digits = is_ext ? 8 : 3;
            if (parse_pos <= id_digits) begin
                ident = {ident[27:0], nib};
            end
            else if (parse_pos == id_digits + 1) begin
                dlc = (nib > MAX_DATA_BYTES) ? 4'(MAX_DATA_BYTES) : nib;
            end
            else begin
                d   = parse_pos - id_digits - 2;
                idx = d >> 1;
                if (idx < dlc && idx < 8) begin
                    sh = idx * 8 + (d[0] ? 0 : 4);
                    data_bytes = data_bytes | (64'(nib) << sh);
                end
            end
        endfunction

        function void note_transaction(logic req, logic [7:0] ch, logic eoc, logic ok);
            result_t     r;
            logic [47:0] text;
            if (req == REQ_OUTCOME) begin
                if (ok) begin
                    push_reply(last_frame_ext ? CHAR_ACK_EXT : CHAR_ACK_STD, 1'b0);
                    push_reply(CHAR_CR, 1'b1);
                end
                else begin
                    push_reply(CHAR_BELL, 1'b1);
                end
                return;
            end
            if (parse_pos == 0) begin
                cmd_letter = ch;
                ident      = '0;
                dlc        = '0;
                data_bytes = '0;
            end
            else begin
                take_digit(nibble_of(ch));
            end
            if (!eoc) begin
                if (parse_pos < POS_MAX) parse_pos = parse_pos + 1;
                return;
            end
            parse_pos = '0;
            case (cmd_letter)
                CMD_VERSION, CMD_SERIAL: begin
                    text = (cmd_letter == CMD_VERSION) ? VERSION_TEXT : SERIAL_TEXT;
                    for (int i = 0; i < 6; i++)
                        push_reply(text[47 - 8 * i -: 8], i == 5);
                end
                CMD_STD_DATA, CMD_EXT_DATA, CMD_STD_RTR, CMD_EXT_RTR: begin
                    r = '0;
                    r.kind    = OUT_FRAME;
                    r.ext     = (cmd_letter == CMD_EXT_DATA || cmd_letter == CMD_EXT_RTR);
                    r.rtr     = (cmd_letter == CMD_STD_RTR || cmd_letter == CMD_EXT_RTR);
                    r.id      = ident[28:0];
                    r.len     = dlc;
                    r.payload = data_bytes;
                    r.last    = 1'b1;
                    last_frame_ext = r.ext;
                    pending.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, result_t want, result_t got);
            errors++;
            if (errors <= 10) begin
                $display("tb: %s", what);
                $display("  exp kind=%0d rtr=%0d ext=%0d id=%h len=%0d pay=%h ch=%h last=%0d",
                         want.kind, want.rtr, want.ext, want.id, want.len, want.payload,
                         want.reply, want.last);
                $display("  got kind=%0d rtr=%0d ext=%0d id=%h len=%0d pay=%h ch=%h last=%0d",
                         got.kind, got.rtr, got.ext, got.id, got.len, got.payload,
                         got.reply, got.last);
            end
        endfunction

        function void check_output(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                flag("result with nothing expected", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.rtr !== want.rtr || got.ext !== want.ext ||
                got.id !== want.id || got.len !== want.len ||
                got.payload !== want.payload || got.reply !== want.reply ||
                got.last !== want.last)
                flag("result mismatch", want, got);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [7:0]  cmd_byte;
    logic        end_of_command;
    logic        tx_ok;
    logic        out_valid;
    logic        out_ready;
    logic        out_kind;
    logic        frame_rtr;
    logic        frame_extended;
    logic [28:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
    logic [7:0]  reply_char;
    logic        last_of_run;

    cmd_parse_scoreboard sb;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    int          hold_left = 0;
    bit          hold_pending = 0;
    result_t     seen;

    ascii_can_command_parser_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .cmd_byte       (cmd_byte),
        .end_of_command (end_of_command),
        .tx_ok          (tx_ok),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_kind       (out_kind),
        .frame_rtr      (frame_rtr),
        .frame_extended (frame_extended),
        .frame_id       (frame_id),
        .frame_length   (frame_length),
        .frame_payload  (frame_payload),
        .reply_char     (reply_char),
        .last_of_run    (last_of_run)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_pending) begin
            hold_pending = 0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
            else if (out_valid && out_ready) begin
                seen.kind    = out_kind;
                seen.rtr     = frame_rtr;
                seen.ext     = frame_extended;
                seen.id      = frame_id;
                seen.len     = frame_length;
                seen.payload = frame_payload;
                seen.reply   = reply_char;
                seen.last    = last_of_run;
                sb.check_output(seen);
            end
        end
    end

    // hold valid and payload until the transaction completes
    task automatic push_item(logic req, logic [7:0] ch, logic eoc, logic ok);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= req;
        cmd_byte       <= ch;
        end_of_command <= eoc;
        tx_ok          <= ok;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        sb.note_transaction(req, ch, eoc, ok);
        items_sent++;
    endtask

    task automatic push_outcome();
        push_item(REQ_OUTCOME, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    task automatic send_line(logic [7:0] line[$]);
        for (int i = 0; i < line.size(); i++) begin
            if (i > 0 && $urandom_range(99) < 4) push_outcome();
            push_item(REQ_BYTE, line[i], i == line.size() - 1, 1'($urandom_range(1)));
        end
    endtask

    task automatic send_text(string s);
        logic [7:0] line[$];
        for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
        send_line(line);
    endtask

    function automatic logic [7:0] digit_char(logic [3:0] v);
        if ($urandom_range(99) < 5) return 8'($urandom_range(255));
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
    endfunction

    task automatic random_command();
        logic [7:0] line[$];
        int         pick;
        int         n_id;
        int         dlc_digit;
        int         n_data;
        int         variant;
        logic       ext;
        pick = $urandom_range(99);
        if (pick < 60 || pick >= 90) begin
            case ($urandom_range(3))
                0:       line.push_back(CMD_STD_DATA);
                1:       line.push_back(CMD_EXT_DATA);
                2:       line.push_back(CMD_STD_RTR);
                default: line.push_back(CMD_EXT_RTR);
            endcase
            ext  = (line[0] == CMD_EXT_DATA || line[0] == CMD_EXT_RTR);
            n_id = ext ? 8 : 3;
            if (pick >= 90) begin
                repeat ($urandom_range(32, 40)) line.push_back(8'($urandom_range(255)));
            end
            else begin
                for (int i = 0; i < n_id; i++) line.push_back(digit_char(4'($urandom_range(15))));
                dlc_digit = ($urandom_range(99) < 75) ? $urandom_range(8) : $urandom_range(9, 15);
                line.push_back(digit_char(4'(dlc_digit)));
                n_data  = 2 * ((dlc_digit > 8) ? 8 : dlc_digit);
                variant = $urandom_range(99);
                if (variant < 12)
                    n_data = -$urandom_range(0, n_id + 1);
                else if (variant < 24)
                    n_data = n_data + $urandom_range(1, 6);
                for (int i = 0; i < n_data; i++)
                    line.push_back(digit_char(4'($urandom_range(15))));
                while (n_data < 0 && line.size() > 1) begin
                    void'(line.pop_back());
                    n_data++;
                end
            end
            send_line(line);
        end
        else if (pick < 70) begin
            line.push_back($urandom_range(1) ? CMD_VERSION : CMD_SERIAL);
            repeat ($urandom_range(0, 2)) line.push_back(8'($urandom_range(255)));
            send_line(line);
        end
        else if (pick < 80) begin
            push_outcome();
        end
        else begin
            line.push_back(8'($urandom_range(255)));
            repeat ($urandom_range(0, 6)) line.push_back(8'($urandom_range(255)));
            send_line(line);
        end
    endtask

    initial
    begin
        int target;
        sb = new();
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        req_type       <= REQ_BYTE;
        cmd_byte       <= 8'h00;
        end_of_command <= 1'b0;
        tx_ok          <= 1'b0;
        out_ready      <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        push_item(REQ_OUTCOME, 8'hFF, 1'b1, 1'b1);
        push_item(REQ_OUTCOME, 8'h00, 1'b0, 1'b0);
        send_text("V");
        send_text("N");
        send_text("O");
        send_text("s");
        send_text("t00195a");
        send_text("TFFFFFFFF1G");
        push_item(REQ_OUTCOME, 8'h54, 1'b0, 1'b1);
        send_text("r");

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            if (ph == 0) hold_pending = 1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_command();
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
